// ----- rtl/core/dcb_pkg.sv -----
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types and constants of the DC blocking filter: transfer payloads,
// sample format codes and configuration register indexes.
// ----------------------------------------------------------------------------
package dcb_pkg;

    // Sample format codes (code 3 behaves as s32)
    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S24 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF3 = 3'd4;

    // Reset values
    localparam logic [1:0]  FORMAT_RESET = FMT_S32;
    localparam logic [31:0] COEFF_RESET  = 32'h4000_0000;

    // Number of coefficient registers in the register map
    localparam int unsigned NUM_COEFFS = 4;

    typedef struct packed {
        logic [1:0]         chan;
        logic signed [31:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         chan_out;
        logic signed [31:0] sample_out;
    } out_item_t;

endpackage

// ----- rtl/core/dcb_calc.sv -----
// ----------------------------------------------------------------------------
// dcb_calc
// Filter datapath: y = x - x_prev + R*y_prev in Q1.31 with saturation and
// symmetric rounding, followed by conversion to the output sample format.
// ----------------------------------------------------------------------------
module dcb_calc (
    input  logic [1:0]         fmt,
    input  logic signed [31:0] x,
    input  logic signed [31:0] x_prev,
    input  logic signed [31:0] y_prev,
    input  logic signed [31:0] coeff,
    output logic signed [31:0] y,
    output logic signed [31:0] res
);
    import dcb_pkg::*;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    logic signed [32:0] diff;
    logic [63:0]        acc_d;
    logic signed [63:0] mult;
    logic [63:0]        prod;
    logic [64:0]        sum65;
    logic [63:0]        acc1;
    logic [63:0]        acc2;
    logic               neg;
    logic [63:0]        mag;
    logic [64:0]        rsum;
    logic [32:0]        rq;

    logic               neg_y;
    logic [31:0]        mag_y;
    logic [32:0]        rs16;
    logic [16:0]        rq16;
    logic [15:0]        res16;
    logic [32:0]        t24;
    logic [24:0]        v24;
    logic [23:0]        res24;

    // Difference term, scaled to the 64-bit accumulator
    assign diff  = {x[31], x} - {x_prev[31], x_prev};
    assign acc_d = {diff, 31'b0};

    // Doubled feedback product; only both operands at full negative scale overflow
    assign mult = coeff * y_prev;
    assign prod = (coeff == S32_MIN && y_prev == S32_MIN) ? S64_MAX : {mult[62:0], 1'b0};

    // Saturating add
    assign sum65 = {acc_d[63], acc_d} + {prod[63], prod};
    assign acc1  = (sum65[64] != sum65[63]) ? (sum65[64] ? S64_MIN : S64_MAX) : sum65[63:0];

    // Saturating double
    assign acc2 = (acc1[63] != acc1[62]) ? (acc1[63] ? S64_MIN : S64_MAX) : {acc1[62:0], 1'b0};

    // High word, rounded half away from zero, saturated
    assign neg  = acc2[63];
    assign mag  = neg ? (64'd0 - acc2) : acc2;
    assign rsum = {1'b0, mag} + 65'h0_8000_0000;
    assign rq   = rsum[64:32];

    always_comb
    begin
        if (neg)
            y = (rq > {1'b0, S32_MIN}) ? S32_MIN : (32'd0 - rq[31:0]);
        else
            y = (rq > {1'b0, S32_MAX}) ? S32_MAX : rq[31:0];
    end

    // s16: symmetric round, saturate
    assign neg_y = y[31];
    assign mag_y = neg_y ? (32'd0 - y) : y;
    assign rs16  = {1'b0, mag_y} + 33'h0_0000_8000;
    assign rq16  = rs16[32:16];

    always_comb
    begin
        if (neg_y)
            res16 = (rq16 > 17'h0_8000) ? 16'h8000 : (16'd0 - rq16[15:0]);
        else
            res16 = (rq16 > 17'h0_7FFF) ? 16'h7FFF : rq16[15:0];
    end

    // s24: round half up by floor shift, saturate
    assign t24   = {y[31], y} + 33'd128;
    assign v24   = t24[32:8];
    assign res24 = (v24[24] != v24[23]) ? (v24[24] ? 24'h80_0000 : 24'h7F_FFFF) : v24[23:0];

    // Output format select
    always_comb
    begin
        unique case (fmt)
            FMT_S16: res = {{16{res16[15]}}, res16};
            FMT_S24: res = {{8{res24[23]}}, res24};
            default: res = y;
        endcase
    end

endmodule

// ----- rtl/core/dc_blocking_filter.sv -----
// ----------------------------------------------------------------------------
// dc_blocking_filter
// First-order DC blocking IIR filter, y = x - x_prev + R*y_prev, with
// per-channel history and Q2.30 coefficients.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_stall   in_item   (chan, sample_in)
//  out       source     out_valid / out_stall out_item  (chan_out, sample_out)
//  cfg       sink       cfg_we                cfg_index, cfg_data
//
//  One transfer per cycle sustained while out_stall is low; a result passes
//  the input register, then multiply-add and rounding into the result
//  register, and is offered on out_valid from there. Channel history is
//  written as the item enters the result register, so the next sample of
//  the same channel sees it at once. Reset clears the history to zero and
//  loads the default configuration. in_stall rises only while both stages
//  are full and out_stall is high. Samples with a channel not below
//  NUM_CHANNELS are dropped on transfer.
// ----------------------------------------------------------------------------
module dc_blocking_filter #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  dcb_pkg::in_item_t                    in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output dcb_pkg::out_item_t                   out_item,
    input  logic                                 cfg_we,
    input  logic [dcb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dcb_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import dcb_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [2:0] NUM_CH_L = 3'(NUM_CHANNELS);

    // Configuration
    logic [1:0]  format_reg;
    logic [31:0] coeff_reg [NUM_COEFFS];

    // Channel history
    logic [31:0] prev_in_reg  [NUM_CHANNELS];
    logic [31:0] prev_out_reg [NUM_CHANNELS];

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_chan_reg;
    logic [31:0] s1_x_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;

    logic        in_xfer;
    logic        chan_ok;
    logic        advance;
    logic [31:0] x_aligned;
    logic [CH_W-1:0] rd_idx;
    logic signed [31:0] y_new;
    logic signed [31:0] res;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FORMAT_RESET;
            for (int i = 0; i < NUM_COEFFS; i++)
                coeff_reg[i] <= COEFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FORMAT: format_reg   <= cfg_data[1:0];
                REG_COEFF0: coeff_reg[0] <= cfg_data;
                REG_COEFF1: coeff_reg[1] <= cfg_data;
                REG_COEFF2: coeff_reg[2] <= cfg_data;
                REG_COEFF3: coeff_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign chan_ok  = {1'b0, in_item.chan} < NUM_CH_L;

    // Align the sample to Q1.31
    always_comb
    begin
        unique case (format_reg)
            FMT_S16: x_aligned = {in_item.sample_in[15:0], 16'b0};
            FMT_S24: x_aligned = {in_item.sample_in[23:0], 8'b0};
            default: x_aligned = in_item.sample_in;
        endcase
    end

    // Input stage control
    always_comb
    begin
        priority if (in_xfer && chan_ok)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && chan_ok)
        begin
            s1_chan_reg <= in_item.chan;
            s1_x_reg    <= x_aligned;
        end
    end

    // Datapath
    assign rd_idx = s1_chan_reg[CH_W-1:0];

    dcb_calc u_calc (
        .fmt    (format_reg),
        .x      (s1_x_reg),
        .x_prev (prev_in_reg[rd_idx]),
        .y_prev (prev_out_reg[rd_idx]),
        .coeff  (coeff_reg[s1_chan_reg]),
        .y      (y_new),
        .res    (res)
    );

    // History update as the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end
        else if (advance)
        begin
            prev_in_reg[rd_idx]  <= s1_x_reg;
            prev_out_reg[rd_idx] <= y_new;
        end
    end

    // Result stage
    always_comb
    begin
        priority if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg.chan_out   <= s1_chan_reg;
            out_item_reg.sample_out <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ----- rtl/core/dcb_checker.sv -----
// ----------------------------------------------------------------------------
// dcb_checker
// Port-level checks of the DC blocking filter, bound to the top level.
// ----------------------------------------------------------------------------
module dcb_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input dcb_pkg::out_item_t out_item
);
    import dcb_pkg::*;

    localparam logic [2:0] NUM_CH_L = 3'(NUM_CHANNELS);

    // No result is offered in the cycle after reset is seen
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // Input back-pressure only comes from a stalled, full result stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without output back-pressure");

    // Results only carry configured channels
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_item.chan_out} < NUM_CH_L)
        else $error("result on channel beyond NUM_CHANNELS");

endmodule

bind dc_blocking_filter dcb_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_dcb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
